/* design/wga_pkg.sv */
// Shared field widths, arithmetic widths and the reset value for the weighted Gram accumulator.
`timescale 1ns / 1ps
`default_nettype none

package wga_pkg;

  // Channel field widths
  localparam int W_WEIGHT = 16;
  localparam int W_IDX    = 3;
  localparam int W_FEAT   = 16;
  localparam int W_DOT    = 48;
  localparam int W_NORM   = 47;
  localparam int W_CNT    = 4;

  // Arithmetic: feature x feature, then weight x product, then drop 16 fraction bits
  localparam int PROD_W     = 2 * W_FEAT;
  localparam int MUL_W      = W_WEIGHT + 1 + PROD_W;
  localparam int WPROD_W    = MUL_W - 1;
  localparam int FRAC_SHIFT = 16;
  localparam int TERM_W     = WPROD_W - FRAC_SHIFT;

  localparam logic [W_CNT-1:0] OBJ_COUNT_RESET = 4'd8;

  // One column store entry: feature and flipped feature of one object
  typedef struct packed {
    logic signed [W_FEAT-1:0] f;
    logic signed [W_FEAT-1:0] g;
  } feat_pair_t;

endpackage

`default_nettype wire

/* design/wga_ifs.sv */
// Channel interfaces of the weighted Gram accumulator: input items, results, configuration.
`timescale 1ns / 1ps
`default_nettype none

interface wga_in_if import wga_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [W_WEIGHT-1:0] weight;
  logic        [W_IDX-1:0]    obj_index;
  logic signed [W_FEAT-1:0]   feature;
  logic signed [W_FEAT-1:0]   feature_flipped;
  logic                       final_dim;

  modport source (
    output valid, weight, obj_index, feature, feature_flipped, final_dim,
    input  ready
  );
  modport sink (
    input  valid, weight, obj_index, feature, feature_flipped, final_dim,
    output ready
  );
endinterface

interface wga_out_if import wga_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [W_IDX-1:0]  row;
  logic        [W_IDX-1:0]  col;
  logic signed [W_DOT-1:0]  dot;
  logic signed [W_DOT-1:0]  dot_flipped;
  logic        [W_NORM-1:0] row_norm;
  logic        [W_NORM-1:0] row_norm_flipped;
  logic                     last;

  modport source (
    output valid, row, col, dot, dot_flipped, row_norm, row_norm_flipped, last,
    input  ready
  );
  modport sink (
    input  valid, row, col, dot, dot_flipped, row_norm, row_norm_flipped, last,
    output ready
  );
endinterface

interface wga_cfg_if import wga_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [W_CNT-1:0] obj_count;

  modport source (output valid, obj_count, input ready);
  modport sink (input valid, obj_count, output ready);
endinterface

`default_nettype wire

/* design/weighted_gram_accumulator_top.sv */
// Top level of the weighted Gram accumulator: column store, shared MAC pipeline, output sequencer.
//
// Usage: items carry one object's feature and flipped feature for one dimension, plus
// the dimension weight. The request whose obj_index is the last object in use
// (obj_count, clamped to 1..MAX_OBJECTS) completes the column and starts an update pass.
// The pass runs one step per cycle through a shared four-stage pipeline (store read,
// feature product, weight product, saturating add into the Gram RAM): n steps per row
// for the pairs plus one step per row for the two norms, n*(n+1) steps in all.
// A completing request therefore keeps items.ready low through the pass and the pipeline drain;
// items.ready stays high for any other request. With final_dim set on the completing
// request the block then emits all n*n pairs, col outer and row inner, each one
// through the results register (read, load and hold states for every pair), and the
// register simply holds while the receiver stalls. After the pair marked last is taken,
// all accumulators are cleared at once (valid bits and norm registers) and items.ready
// returns. The cfg channel is always ready; write obj_count only while idle.
// Reset: accumulators read as zero, obj_count is 8, the column store is undefined
// until written. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module weighted_gram_accumulator_top import wga_pkg::*; #(
  parameter int MAX_OBJECTS = 8,
  parameter int ACC_WIDTH   = 48
) (
  input  logic       clk,
  input  logic       rst,
  wga_cfg_if.sink    cfg,
  wga_in_if.sink     items,
  wga_out_if.source  results
);

  localparam int IDX_W      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int PAIR_W     = 2 * IDX_W;
  localparam int GRAM_DEPTH = 1 << PAIR_W;
  localparam int EXT_W      = (ACC_WIDTH > W_DOT) ? ACC_WIDTH : W_DOT;

  localparam logic [W_CNT-1:0] CNT_MAX = W_CNT'(MAX_OBJECTS);

  localparam logic signed [EXT_W-1:0] DOT_MAX  = {{(EXT_W - W_DOT + 1){1'b0}},
                                                  {(W_DOT - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] DOT_MIN  = ~DOT_MAX;
  localparam logic signed [EXT_W-1:0] NORM_MAX = {{(EXT_W - W_NORM){1'b0}},
                                                  {W_NORM{1'b1}}};

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MAC      = 6'b000010,
    S_DRAIN    = 6'b000100,
    S_OUT_READ = 6'b001000,
    S_OUT_LOAD = 6'b010000,
    S_OUT_HOLD = 6'b100000
  } state_t;

  // Control carried along the MAC pipeline
  typedef struct packed {
    logic             vld;
    logic             norm;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } stage_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] flip;
    logic signed [ACC_WIDTH-1:0] dot;
  } gram_entry_t;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [TERM_W-1:0]    t
  );
    logic [ACC_WIDTH:0] sum;
    sum = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH + 1)'(t);
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      return sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                            : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    end
    return sum[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [W_DOT-1:0] clamp_dot(input logic signed [ACC_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve > DOT_MAX) return DOT_MAX[W_DOT-1:0];
    if (ve < DOT_MIN) return DOT_MIN[W_DOT-1:0];
    return ve[W_DOT-1:0];
  endfunction

  function automatic logic [W_NORM-1:0] clamp_norm(input logic signed [ACC_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve < 0) return '0;
    if (ve > NORM_MAX) return NORM_MAX[W_NORM-1:0];
    return ve[W_NORM-1:0];
  endfunction

  // Configuration
  logic [W_CNT-1:0] obj_count;
  logic [W_CNT-1:0] n_eff;
  logic [IDX_W-1:0] n_last;

  // Sequencer
  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  row_cnt;
  logic [IDX_W-1:0]  col_cnt;
  logic              norm_step;
  logic [W_WEIGHT-1:0] weight;
  logic              fin;

  // Column store
  feat_pair_t        col_mem [MAX_OBJECTS];
  feat_pair_t        rd_x;
  feat_pair_t        rd_r;

  // Pipeline
  stage_t            st1;
  stage_t            st2;
  stage_t            st3;
  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [WPROD_W-1:0] wprod_a;
  logic signed [WPROD_W-1:0] wprod_b;
  logic signed [TERM_W-1:0]  term_a;
  logic signed [TERM_W-1:0]  term_b;
  logic signed [ACC_WIDTH-1:0] old_a;
  logic signed [ACC_WIDTH-1:0] old_b;

  // Gram RAM and its valid bits
  gram_entry_t       gram_mem [GRAM_DEPTH];
  logic [GRAM_DEPTH-1:0] gram_vld;
  gram_entry_t       gram_rd;
  logic              gram_rd_vld;
  logic [PAIR_W-1:0] gram_raddr;
  logic [PAIR_W-1:0] gram_waddr;

  // Norm accumulators
  logic signed [ACC_WIDTH-1:0] norm_acc      [MAX_OBJECTS];
  logic signed [ACC_WIDTH-1:0] norm_acc_flip [MAX_OBJECTS];

  // Result register
  logic [W_IDX-1:0]  res_row;
  logic [W_IDX-1:0]  res_col;
  logic [W_DOT-1:0]  res_dot;
  logic [W_DOT-1:0]  res_dot_flip;
  logic [W_NORM-1:0] res_norm;
  logic [W_NORM-1:0] res_norm_flip;
  logic              res_last;

  logic in_fire;
  logic out_fire;
  logic idx_ok;
  logic col_done;
  logic pipe_busy;
  logic pair_last;

  // Effective object count: 0 acts as 1, above the store depth acts as the depth
  always_comb begin
    if (obj_count == '0) begin
      n_eff = W_CNT'(1);
    end else if (obj_count > CNT_MAX) begin
      n_eff = CNT_MAX;
    end else begin
      n_eff = obj_count;
    end
  end
  assign n_last = IDX_W'(n_eff - W_CNT'(1));

  assign in_fire   = items.valid & items.ready;
  assign out_fire  = results.valid & results.ready;
  assign idx_ok    = {1'b0, items.obj_index} < CNT_MAX;
  assign col_done  = idx_ok && ({1'b0, items.obj_index} == (n_eff - W_CNT'(1)));
  assign pipe_busy = st1.vld | st2.vld | st3.vld;
  assign pair_last = (row_cnt == n_last) && (col_cnt == n_last);

  assign cfg.ready   = 1'b1;
  assign items.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_count <= OBJ_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      obj_count <= cfg.obj_count;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && col_done) state_next = S_MAC;
      end
      S_MAC: begin
        if (norm_step && (row_cnt == n_last)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!pipe_busy) state_next = fin ? S_OUT_READ : S_IDLE;
      end
      S_OUT_READ: state_next = S_OUT_LOAD;
      S_OUT_LOAD: state_next = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (out_fire) state_next = res_last ? S_IDLE : S_OUT_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_cnt   <= '0;
      col_cnt   <= '0;
      norm_step <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          row_cnt   <= '0;
          col_cnt   <= '0;
          norm_step <= 1'b0;
        end
        S_MAC: begin
          // Per row: every col, then one norm step
          if (!norm_step) begin
            if (col_cnt == n_last) begin
              norm_step <= 1'b1;
            end else begin
              col_cnt <= col_cnt + IDX_W'(1);
            end
          end else begin
            norm_step <= 1'b0;
            col_cnt   <= '0;
            row_cnt   <= (row_cnt == n_last) ? '0 : row_cnt + IDX_W'(1);
          end
        end
        S_OUT_HOLD: begin
          // Output order: row inner, col outer
          if (out_fire) begin
            if (row_cnt == n_last) begin
              row_cnt <= '0;
              col_cnt <= pair_last ? '0 : col_cnt + IDX_W'(1);
            end else begin
              row_cnt <= row_cnt + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Weight and final flag of the completing request
  always_ff @(posedge clk) begin
    if (in_fire && col_done) begin
      weight <= items.weight;
      fin    <= items.final_dim;
    end
  end

  // Column store: written on every request in range, two registered read ports
  always_ff @(posedge clk) begin
    if (in_fire && idx_ok) begin
      col_mem[items.obj_index[IDX_W-1:0]] <= '{f: items.feature, g: items.feature_flipped};
    end
    rd_x <= col_mem[norm_step ? row_cnt : col_cnt];
    rd_r <= col_mem[row_cnt];
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      st1 <= '0;
      st2 <= '0;
      st3 <= '0;
    end else begin
      st1 <= '{vld: (state == S_MAC), norm: norm_step, row: row_cnt, col: col_cnt};
      st2 <= st1;
      st3 <= st2;
    end
  end

  // Stage 1: feature products. On a norm step rd_x holds the row entry.
  always_ff @(posedge clk) begin
    prod_a <= PROD_W'(rd_x.f * rd_r.f);
    prod_b <= PROD_W'((st1.norm ? rd_r.g : rd_x.f) * rd_r.g);
  end

  // Stage 2: weight products; capture the accumulator read for this pair
  assign mul_a = $signed({1'b0, weight}) * prod_a;
  assign mul_b = $signed({1'b0, weight}) * prod_b;

  always_ff @(posedge clk) begin
    wprod_a <= mul_a[WPROD_W-1:0];
    wprod_b <= mul_b[WPROD_W-1:0];
    old_a   <= gram_rd_vld ? gram_rd.dot  : '0;
    old_b   <= gram_rd_vld ? gram_rd.flip : '0;
  end

  // Stage 3: floor shift and saturating add
  assign term_a = wprod_a[WPROD_W-1:FRAC_SHIFT];
  assign term_b = wprod_b[WPROD_W-1:FRAC_SHIFT];

  assign gram_raddr = (state == S_OUT_READ) ? {col_cnt, row_cnt} : {st1.col, st1.row};
  assign gram_waddr = {st3.col, st3.row};

  always_ff @(posedge clk) begin
    if (st3.vld && !st3.norm) begin
      gram_mem[gram_waddr] <= '{flip: sat_add(old_b, term_b), dot: sat_add(old_a, term_a)};
    end
    gram_rd     <= gram_mem[gram_raddr];
    gram_rd_vld <= gram_vld[gram_raddr];
  end

  // Valid bits and norms: cleared at once after the last pair is taken
  always_ff @(posedge clk) begin
    if (rst || (out_fire && res_last)) begin
      gram_vld <= '0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        norm_acc[i]      <= '0;
        norm_acc_flip[i] <= '0;
      end
    end else if (st3.vld) begin
      if (st3.norm) begin
        norm_acc[st3.row]      <= sat_add(norm_acc[st3.row], term_a);
        norm_acc_flip[st3.row] <= sat_add(norm_acc_flip[st3.row], term_b);
      end else begin
        gram_vld[gram_waddr] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_OUT_LOAD) begin
      res_row       <= W_IDX'(row_cnt);
      res_col       <= W_IDX'(col_cnt);
      res_dot       <= clamp_dot(gram_rd_vld ? gram_rd.dot : '0);
      res_dot_flip  <= clamp_dot(gram_rd_vld ? gram_rd.flip : '0);
      res_norm      <= clamp_norm(norm_acc[row_cnt]);
      res_norm_flip <= clamp_norm(norm_acc_flip[row_cnt]);
      res_last      <= pair_last;
    end
  end

  assign results.valid            = (state == S_OUT_HOLD);
  assign results.row              = res_row;
  assign results.col              = res_col;
  assign results.dot              = res_dot;
  assign results.dot_flipped      = res_dot_flip;
  assign results.row_norm         = res_norm;
  assign results.row_norm_flipped = res_norm_flip;
  assign results.last             = res_last;

endmodule

`default_nettype wire
